// ===== src/c2aer_pkg.sv =====
// Package for the cartesian to azimuth/elevation/range block.
// Holds widths, pipeline latencies, the CORDIC arctangent table and angle helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package c2aer_pkg;

  localparam int COORD_BITS  = 24;
  localparam int ANGLE_BITS  = 16;
  localparam int GUARD       = 16;
  localparam int ITERS       = 30;

  localparam int DW          = COORD_BITS + 1;          // coordinate difference
  localparam int XW          = COORD_BITS + GUARD + 6;  // CORDIC datapath
  localparam int ACC_W       = 32;                      // 2^32 units per turn
  localparam int OUT_ANGLE_W = 16;
  localparam int RANGE_W     = 25;
  localparam int SQ_W        = 2 * DW;
  localparam int SUM_W       = 2 * DW + 2;
  localparam int ROOT_W      = COORD_BITS + 1;
  localparam int KQ_W        = 31;
  localparam int PROD_W      = DW + KQ_W;
  localparam int Y2_SH       = 30 - GUARD;

  localparam logic [KQ_W-1:0]    KQ30      = 31'd1768195363;
  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

  localparam int CORDIC_LAT = ITERS + 1;
  localparam int RANGE_DLY  = 2 * CORDIC_LAT - ROOT_W;
  localparam int LATENCY    = 2 * CORDIC_LAT + 4;

  localparam logic [ACC_W-1:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [ACC_W-1:0] QUARTER_NEG = 32'hC000_0000;

  typedef logic signed [XW-1:0]    coord_t;
  typedef logic [ACC_W-1:0]        acc_t;
  typedef logic [OUT_ANGLE_W-1:0]  angle_t;

  // Side data that travels through a CORDIC pipeline with its transaction.
  typedef struct packed {
    coord_t y2;
    angle_t az;
  } tag_t;

  function automatic acc_t atan_entry(input int i);
    acc_t a;
    unique case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round the accumulator to ANGLE_BITS and fit it into the output field.
  function automatic angle_t angle_out(input acc_t a);
    acc_t                  s;
    logic [ANGLE_BITS-1:0] v;
    s = a + (ACC_W'(1) << (ACC_W - ANGLE_BITS - 1));
    v = s[ACC_W-1 -: ANGLE_BITS];
    return OUT_ANGLE_W'(signed'(v));
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

endpackage

// ===== src/c2aer_cordic.sv =====
// Pipelined CORDIC vectoring unit: quadrant pre-rotation, then one stage per iteration.
// Depends on c2aer_pkg for widths, the arctangent table and the side-data type.
`timescale 1ns / 1ps

module c2aer_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  c2aer_pkg::coord_t   in_x,
  input  c2aer_pkg::coord_t   in_y,
  input  c2aer_pkg::tag_t     in_tag,
  output logic                out_valid,
  output c2aer_pkg::coord_t   out_mag,
  output c2aer_pkg::acc_t     out_acc,
  output c2aer_pkg::tag_t     out_tag
);

  c2aer_pkg::coord_t xs   [c2aer_pkg::ITERS+1];
  c2aer_pkg::coord_t ys   [c2aer_pkg::ITERS+1];
  c2aer_pkg::acc_t   acc  [c2aer_pkg::ITERS+1];
  c2aer_pkg::tag_t   tag  [c2aer_pkg::ITERS+1];
  logic              zf   [c2aer_pkg::ITERS+1];
  logic              vld  [c2aer_pkg::ITERS+1];

  // Bring x to the right half plane; a zero vector is flagged so its angle reads zero.
  always_ff @(posedge clk) begin
    zf[0]  <= (in_x == '0) && (in_y == '0);
    tag[0] <= in_tag;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        xs[0]  <= in_y;
        ys[0]  <= -in_x;
        acc[0] <= c2aer_pkg::QUARTER_POS;
      end else begin
        xs[0]  <= -in_y;
        ys[0]  <= in_x;
        acc[0] <= c2aer_pkg::QUARTER_NEG;
      end
    end else begin
      xs[0]  <= in_x;
      ys[0]  <= in_y;
      acc[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < c2aer_pkg::ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      zf[i+1]  <= zf[i];
      tag[i+1] <= tag[i];
      if (ys[i] > 0) begin
        xs[i+1]  <= xs[i] + (ys[i] >>> i);
        ys[i+1]  <= ys[i] - (xs[i] >>> i);
        acc[i+1] <= acc[i] + c2aer_pkg::atan_entry(i);
      end else begin
        xs[i+1]  <= xs[i] - (ys[i] >>> i);
        ys[i+1]  <= ys[i] + (xs[i] >>> i);
        acc[i+1] <= acc[i] - c2aer_pkg::atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[c2aer_pkg::ITERS];
  assign out_mag   = xs[c2aer_pkg::ITERS];
  assign out_acc   = zf[c2aer_pkg::ITERS] ? '0 : acc[c2aer_pkg::ITERS];
  assign out_tag   = tag[c2aer_pkg::ITERS];

endmodule

// ===== src/c2aer_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, then round to nearest.
// Depends on c2aer_pkg for widths and the range saturation limit.
`timescale 1ns / 1ps

module c2aer_isqrt (
  input  logic                               clk,
  input  logic [c2aer_pkg::SUM_W-1:0]        in_sum,
  output logic [c2aer_pkg::RANGE_W-1:0]      out_root
);

  // rem holds sum - root^2 at each stage.
  logic [c2aer_pkg::SUM_W-1:0]  rem  [c2aer_pkg::ROOT_W+1];
  logic [c2aer_pkg::ROOT_W-1:0] root [c2aer_pkg::ROOT_W+1];
  logic [c2aer_pkg::ROOT_W:0]   rounded;

  assign rem[0]  = in_sum;
  assign root[0] = '0;

  for (genvar k = 0; k < c2aer_pkg::ROOT_W; k++) begin : g_bit
    localparam int B = c2aer_pkg::ROOT_W - 1 - k;
    logic [c2aer_pkg::SUM_W-1:0] trial;

    assign trial = (c2aer_pkg::SUM_W'(root[k]) << (B + 1))
                 | (c2aer_pkg::SUM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rem[k] >= trial) begin
        rem[k+1]  <= rem[k] - trial;
        root[k+1] <= root[k] | (c2aer_pkg::ROOT_W'(1) << B);
      end else begin
        rem[k+1]  <= rem[k];
        root[k+1] <= root[k];
      end
    end
  end

  // The sum lies past r*(r+1) exactly when the remainder exceeds r.
  always_comb begin
    if (rem[c2aer_pkg::ROOT_W] > c2aer_pkg::SUM_W'(root[c2aer_pkg::ROOT_W])) begin
      rounded = (c2aer_pkg::ROOT_W+1)'(root[c2aer_pkg::ROOT_W]) + 1'b1;
    end else begin
      rounded = (c2aer_pkg::ROOT_W+1)'(root[c2aer_pkg::ROOT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (64'(rounded) > 64'(c2aer_pkg::RANGE_MAX)) begin
      out_root <= c2aer_pkg::RANGE_MAX;
    end else begin
      out_root <= c2aer_pkg::RANGE_W'(rounded);
    end
  end

endmodule

// ===== src/cartesian_to_azimuth_elevation_range.sv =====
// Top level: viewer/target points to azimuth, elevation and range.
// Depends on c2aer_pkg, c2aer_cordic (two cascaded units) and c2aer_isqrt.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | start, busy          | from_x, from_y, from_z, to_x, to_y, to_z
//   result   | done (one-cycle)     | azimuth, elevation, range
//
// One transaction enters per clock while busy is low. Each result passes through the
// difference, multiply and setup registers, the two 31-stage CORDIC pipelines and the
// output registers. Busy is high only during reset. Synchronous reset clears all
// valid bits, so no result appears for a transaction cut by reset.
// The receiver cannot stall: done is a strobe and the pipeline always advances.
`timescale 1ns / 1ps

module cartesian_to_azimuth_elevation_range (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  output logic                                         busy,
  input  logic signed [c2aer_pkg::COORD_BITS-1:0]      from_x,
  input  logic signed [c2aer_pkg::COORD_BITS-1:0]      from_y,
  input  logic signed [c2aer_pkg::COORD_BITS-1:0]      from_z,
  input  logic signed [c2aer_pkg::COORD_BITS-1:0]      to_x,
  input  logic signed [c2aer_pkg::COORD_BITS-1:0]      to_y,
  input  logic signed [c2aer_pkg::COORD_BITS-1:0]      to_z,
  output logic                                         done,
  output logic signed [c2aer_pkg::OUT_ANGLE_W-1:0]     azimuth,
  output logic signed [c2aer_pkg::OUT_ANGLE_W-1:0]     elevation,
  output logic [c2aer_pkg::RANGE_W-1:0]                range
);

  logic                              vld_a, vld_b, vld_c;
  logic signed [c2aer_pkg::DW-1:0]   dx_a, dy_a, dz_a;
  logic signed [c2aer_pkg::DW-1:0]   dx_b, dy_b;
  logic [c2aer_pkg::SQ_W-1:0]        sq_x, sq_y, sq_z;
  logic [c2aer_pkg::PROD_W-1:0]      kprod;
  logic                              dz_pos;
  logic [c2aer_pkg::SUM_W-1:0]       sum_c;
  c2aer_pkg::coord_t                 x_c, y_c, y2_c;
  logic [c2aer_pkg::PROD_W-1:0]      y2_mag;

  logic                              v1, v2;
  c2aer_pkg::coord_t                 mag1;
  c2aer_pkg::acc_t                   acc1, acc2;
  c2aer_pkg::tag_t                   tag_in1, tag1, tag_in2, tag2;
  logic [c2aer_pkg::RANGE_W-1:0]     root;
  logic [c2aer_pkg::RANGE_W-1:0]     rng_dly [c2aer_pkg::RANGE_DLY];

  assign busy = rst;

  // Differences.
  always_ff @(posedge clk) begin
    dx_a <= c2aer_pkg::DW'(to_x) - c2aer_pkg::DW'(from_x);
    dy_a <= c2aer_pkg::DW'(to_y) - c2aer_pkg::DW'(from_y);
    dz_a <= c2aer_pkg::DW'(to_z) - c2aer_pkg::DW'(from_z);
  end

  // Squares for the range, and |dz| times the CORDIC gain for the elevation input.
  always_ff @(posedge clk) begin
    sq_x   <= c2aer_pkg::SQ_W'(c2aer_pkg::mag(dx_a)) * c2aer_pkg::SQ_W'(c2aer_pkg::mag(dx_a));
    sq_y   <= c2aer_pkg::SQ_W'(c2aer_pkg::mag(dy_a)) * c2aer_pkg::SQ_W'(c2aer_pkg::mag(dy_a));
    sq_z   <= c2aer_pkg::SQ_W'(c2aer_pkg::mag(dz_a)) * c2aer_pkg::SQ_W'(c2aer_pkg::mag(dz_a));
    kprod  <= c2aer_pkg::PROD_W'(c2aer_pkg::mag(dz_a)) * c2aer_pkg::PROD_W'(c2aer_pkg::KQ30);
    dz_pos <= dz_a > 0;
    dx_b   <= dx_a;
    dy_b   <= dy_a;
  end

  assign y2_mag = (kprod + (c2aer_pkg::PROD_W'(1) << (c2aer_pkg::Y2_SH - 1)))
                  >> c2aer_pkg::Y2_SH;

  // Sum of squares and scaled CORDIC inputs; the elevation's y is negative for dz > 0.
  always_ff @(posedge clk) begin
    sum_c <= c2aer_pkg::SUM_W'(sq_x) + c2aer_pkg::SUM_W'(sq_y) + c2aer_pkg::SUM_W'(sq_z);
    x_c   <= c2aer_pkg::XW'(dy_b) <<< c2aer_pkg::GUARD;
    y_c   <= c2aer_pkg::XW'(dx_b) <<< c2aer_pkg::GUARD;
    y2_c  <= dz_pos ? -c2aer_pkg::XW'(y2_mag) : c2aer_pkg::XW'(y2_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      vld_a <= start;
      vld_b <= vld_a;
      vld_c <= vld_b;
    end
  end

  assign tag_in1 = '{y2: y2_c, az: '0};

  c2aer_cordic u_az (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_c),
    .in_x      (x_c),
    .in_y      (y_c),
    .in_tag    (tag_in1),
    .out_valid (v1),
    .out_mag   (mag1),
    .out_acc   (acc1),
    .out_tag   (tag1)
  );

  assign tag_in2 = '{y2: '0, az: c2aer_pkg::angle_out(acc1)};

  c2aer_cordic u_el (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_x      (mag1),
    .in_y      (tag1.y2),
    .in_tag    (tag_in2),
    .out_valid (v2),
    .out_mag   (),
    .out_acc   (acc2),
    .out_tag   (tag2)
  );

  c2aer_isqrt u_rng (
    .clk      (clk),
    .in_sum   (sum_c),
    .out_root (root)
  );

  // Delay the range so it lines up with the elevation result.
  always_ff @(posedge clk) begin
    rng_dly[0] <= root;
    for (int i = 1; i < c2aer_pkg::RANGE_DLY; i++) begin
      rng_dly[i] <= rng_dly[i-1];
    end
  end

  assign range = rng_dly[c2aer_pkg::RANGE_DLY-1];

  always_ff @(posedge clk) begin
    azimuth   <= tag2.az;
    elevation <= c2aer_pkg::angle_out(acc2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(c2aer_pkg::LATENCY) done)
    else $error("transaction did not complete at the pipeline latency");

  a_coincident : assert property (@(posedge clk) disable iff (rst)
    (done && range == '0) |-> (azimuth == '0 && elevation == '0))
    else $error("zero range with a nonzero angle");

  a_reset_clears : assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule
